### rtl/po_pkg.sv
package po_pkg;

    localparam int INV_SR_W = 41;
    localparam logic [INV_SR_W-1:0] INV_SR_RESET = 41'd5864062015;

    localparam logic REG_INV_SR = 1'b0;

    localparam logic [31:0] SYNC_ONE   = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] WAVE_ONE   = 32'h4000_0000;

    typedef struct packed {
        logic        sync_load;
        logic [31:0] load_phase;
        logic [31:0] offs;
        logic        step_neg;
        logic [31:0] step;
    } t_cmd;

endpackage

### rtl/parabolic_oscillator.sv
// A beat passes front stages f1 and f2, the command queue, back stages b1 and b2
// and the result queue before it can be popped; the phase loop is one add stage
// in the back end. Throughput: one beat per cycle when neither side stalls.
// The command queue and result queue each hold four beats by default.
// Reset is synchronous and active low; it clears the phase, the previous offset
// and both queues, and loads inv_sample_rate with the 48 kHz value.
module parabolic_oscillator #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_freq_hz,
    input  logic [31:0]         i_phase_offset,
    input  logic signed [31:0]  i_sync_value,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_wave_sample
);

    import po_pkg::*;

    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic [INV_SR_W-1:0]  r_inv_sr;
    logic                 reg_sel;

    logic                 cmd_valid;
    t_cmd                 cmd_in;
    t_cmd                 cmd_head;
    logic [$bits(t_cmd)-1:0] cmd_head_bits;
    logic [CMD_CNT_W-1:0] cmd_count;
    logic                 cmd_pop;

    logic                 wave_valid;
    logic signed [31:0]   wave;
    logic [31:0]          out_head;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_pop;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3] == REG_INV_SR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_sr <= INV_SR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_inv_sr <= pwdata[INV_SR_W-1:0];
        end
    end

    assign prdata = reg_sel ? 64'(r_inv_sr) : 64'd0;

    po_front #(
        .CMD_DEPTH(CMD_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_freq_hz      (i_freq_hz),
        .i_phase_offset (i_phase_offset),
        .i_sync_value   (i_sync_value),
        .i_inv_sr       (r_inv_sr),
        .i_queue_count  (cmd_count),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd_in)
    );

    po_queue #(
        .DEPTH(CMD_DEPTH),
        .WIDTH($bits(t_cmd))
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head_bits),
        .o_count (cmd_count)
    );

    assign cmd_head = t_cmd'(cmd_head_bits);

    po_back #(
        .CMD_DEPTH(CMD_DEPTH),
        .OUT_DEPTH(OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_head),
        .i_cmd_count  (cmd_count),
        .i_out_count  (out_count),
        .o_cmd_pop    (cmd_pop),
        .o_wave_valid (wave_valid),
        .o_wave       (wave)
    );

    po_queue #(
        .DEPTH(OUT_DEPTH),
        .WIDTH(32)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wave_valid),
        .i_data  (wave),
        .i_pop   (out_pop),
        .o_data  (out_head),
        .o_count (out_count)
    );

    assign empty         = out_count == '0;
    assign out_pop       = pop && !empty;
    assign o_wave_sample = $signed(out_head);

endmodule

### rtl/po_queue.sv
module po_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == CNT_W'(DEPTH)))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Queue count exceeds the depth.");

endmodule

### rtl/po_front.sv
module po_front #(
    parameter int CMD_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [31:0]              i_freq_hz,
    input  logic [31:0]                     i_phase_offset,
    input  logic signed [31:0]              i_sync_value,
    input  logic [po_pkg::INV_SR_W-1:0]     i_inv_sr,
    input  logic [$clog2(CMD_DEPTH+1)-1:0]  i_queue_count,
    output logic                            o_cmd_valid,
    output po_pkg::t_cmd                    o_cmd
);

    import po_pkg::*;

    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    logic             accept;
    logic [31:0]      freq_bits;
    logic [31:0]      sync_bits;
    logic [CNT_W:0]   committed;

    logic             r_f1_valid;
    logic [31:0]      r_f1_mag;
    logic             r_f1_neg;
    logic             r_f1_sync_load;
    logic [31:0]      r_f1_load_phase;
    logic [31:0]      r_f1_offs;

    logic             r_f2_valid;
    logic [40:0]      r_f2_hi;
    logic [31:0]      r_f2_lo;
    logic             r_f2_neg;
    logic             r_f2_sync_load;
    logic [31:0]      r_f2_load_phase;
    logic [31:0]      r_f2_offs;

    logic [63:0]      prod_lo;
    logic [41:0]      step_sum;

    assign freq_bits = i_freq_hz;
    assign sync_bits = i_sync_value;

    assign committed = {1'b0, i_queue_count} + (CNT_W+1)'(r_f1_valid)
                     + (CNT_W+1)'(r_f2_valid);
    assign full      = committed >= (CNT_W+1)'(CMD_DEPTH);
    assign accept    = push && !full;

    assign prod_lo = 64'(r_f1_mag) * 64'(i_inv_sr[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_neg        <= freq_bits[31];
            r_f1_mag        <= freq_bits[31] ? (~freq_bits + 32'd1) : freq_bits;
            r_f1_sync_load  <= (sync_bits != '0) && (sync_bits <= SYNC_ONE);
            r_f1_load_phase <= {sync_bits[29:0], 2'b00};
            r_f1_offs       <= i_phase_offset;
        end
        if (r_f1_valid) begin
            r_f2_hi         <= 41'(r_f1_mag) * 41'(i_inv_sr[INV_SR_W-1:32]);
            r_f2_lo         <= prod_lo[63:32];
            r_f2_neg        <= r_f1_neg;
            r_f2_sync_load  <= r_f1_sync_load;
            r_f2_load_phase <= r_f1_load_phase;
            r_f2_offs       <= r_f1_offs;
        end
    end

    assign step_sum = 42'(r_f2_hi) + 42'(r_f2_lo);

    always_comb begin
        o_cmd.sync_load  = r_f2_sync_load;
        o_cmd.load_phase = r_f2_load_phase;
        o_cmd.offs       = r_f2_offs;
        o_cmd.step_neg   = r_f2_neg;
        o_cmd.step       = (step_sum[41:32] != '0) ? 32'd0 : step_sum[31:0];
    end

    assign o_cmd_valid = r_f2_valid;

    a_f1_to_f2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid |=> r_f2_valid)
        else $error("Front stage lost a beat.");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (CNT_W+1)'(CMD_DEPTH))
        else $error("Front committed more beats than the queue holds.");

    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_f1_valid && !r_f2_valid && i_queue_count == '0) |-> !full)
        else $error("Front reports full while idle.");

endmodule

### rtl/po_back.sv
module po_back #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  po_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(CMD_DEPTH+1)-1:0]  i_cmd_count,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]  i_out_count,
    output logic                            o_cmd_pop,
    output logic                            o_wave_valid,
    output logic signed [31:0]              o_wave
);

    import po_pkg::*;

    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    logic [OCNT_W:0]  committed;
    logic             pop;
    logic [31:0]      phase;
    logic [31:0]      n_phase;
    logic [31:0]      twice;
    logic [31:0]      fold;

    logic [31:0]      r_phase;
    logic [31:0]      r_prev;

    logic             r_b1_valid;
    logic [31:0]      r_b1_a;
    logic             r_b1_neg;

    logic             r_b2_valid;
    logic [31:0]      r_b2_sq;
    logic             r_b2_neg;

    logic [63:0]      sq;
    logic [31:0]      mag;

    assign committed = {1'b0, i_out_count} + (OCNT_W+1)'(r_b1_valid)
                     + (OCNT_W+1)'(r_b2_valid);
    assign pop = (i_cmd_count != '0) && (committed < (OCNT_W+1)'(OUT_DEPTH));

    always_comb begin
        if (i_cmd.sync_load) begin
            phase = i_cmd.load_phase;
        end else begin
            phase = r_phase + i_cmd.offs - r_prev;
        end
        if (i_cmd.step_neg) begin
            n_phase = phase - i_cmd.step;
        end else begin
            n_phase = phase + i_cmd.step;
        end
        twice = {phase[30:0], 1'b0};
        fold  = twice[31] ? (twice - HALF_TURN) : (HALF_TURN - twice);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_prev     <= '0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_prev  <= i_cmd.offs;
            end
            r_b1_valid <= pop;
            r_b2_valid <= r_b1_valid;
        end
    end

    assign sq = 64'(r_b1_a) * 64'(r_b1_a);

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b1_a   <= fold;
            r_b1_neg <= phase > HALF_TURN;
        end
        if (r_b1_valid) begin
            r_b2_sq  <= sq[63:32];
            r_b2_neg <= r_b1_neg;
        end
    end

    assign mag          = WAVE_ONE - r_b2_sq;
    assign o_wave       = $signed(r_b2_neg ? (~mag + 32'd1) : mag);
    assign o_wave_valid = r_b2_valid;
    assign o_cmd_pop    = pop;

    a_b1_to_b2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_valid |=> r_b2_valid)
        else $error("Back stage lost a beat.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> i_cmd_count != '0)
        else $error("Back read an empty command queue.");

    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (OCNT_W+1)'(OUT_DEPTH))
        else $error("Back committed more beats than the result queue holds.");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import po_pkg::*;

    typedef enum logic [0:0] {
        ROW_BEAT,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] freq;
        logic [31:0] offs;
        logic [31:0] sync;
        logic        pinned;
        logic [31:0] wave;
        logic [63:0] cfg;
    } t_row;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 6;
    localparam int BEATS_PER_PHASE = 150;
    localparam int QUIET_BEATS = 100;
    localparam logic [63:0] INV_SR_MAX = 64'h100_0000_0000;
    localparam logic [63:0] INV_SR_FULL_TURN = 64'h2_0000_0000;
    localparam logic [31:0] FREQ_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FREQ_MIN = 32'h8000_0000;
    localparam logic [31:0] AUDIO_SPAN = 32'd1310720000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_freq_hz = '0;
    logic [31:0] i_phase_offset = '0;
    logic [31:0] i_sync_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_wave_sample;

    logic        pin_valid = 1'b0;
    logic [31:0] pin_wave = '0;
    bit          no_idle = 1'b0;

    logic [31:0]         osc_phase = '0;
    logic [31:0]         osc_prev_offset = '0;
    logic [INV_SR_W-1:0] osc_inv_sr = INV_SR_RESET;

    logic [31:0] wave_due[$];
    t_row        stim_table[$];

    int mismatches = 0;
    int beats_in = 0;
    int samples_out = 0;
    int sync_loads = 0;
    int rate_writes = 0;
    int cycles = 0;

    parabolic_oscillator u_top (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] wave_of_phase(input logic [31:0] p);
        logic [31:0] f;
        logic [63:0] a;
        logic [31:0] y;
        f = {p[30:0], 1'b0};
        a = (f >= HALF_TURN) ? 64'(f - HALF_TURN) : 64'(HALF_TURN - f);
        y = WAVE_ONE - 32'((a * a) >> 32);
        if (p > HALF_TURN) y = -y;
        return y;
    endfunction

    function automatic logic [31:0] turn_advance(input logic [31:0] mag,
                                                 input logic [INV_SR_W-1:0] inv);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] s;
        hi = 64'(mag) * 64'(inv[40:32]);
        lo = (64'(mag) * 64'(inv[31:0])) >> 32;
        s = hi + lo;
        if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
        return s[31:0];
    endfunction

    always @(posedge i_clk) begin
        logic        load;
        logic [31:0] p;
        logic [31:0] mag;
        logic [31:0] st;
        logic [31:0] exp_wave;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && psel && penable && pwrite && pready &&
            paddr == {REG_INV_SR, 3'b000}) begin
            osc_inv_sr = pwdata[INV_SR_W-1:0];
            rate_writes++;
        end
        if (i_rst_n && pop && !empty) begin
            samples_out++;
            if (wave_due.size() == 0) begin
                $error("wave_sample: no sample expected, got %0d", $signed(o_wave_sample));
                mismatches++;
            end else begin
                exp_wave = wave_due.pop_front();
                if (o_wave_sample !== exp_wave) begin
                    $error("wave_sample: expected %0d, got %0d",
                           $signed(exp_wave), $signed(o_wave_sample));
                    mismatches++;
                end
            end
        end
        if (i_rst_n && push && !full) begin
            beats_in++;
            load = (i_sync_value != 0) && (i_sync_value <= SYNC_ONE);
            if (load) begin
                sync_loads++;
                p = {i_sync_value[29:0], 2'b00};
            end else begin
                p = osc_phase + i_phase_offset - osc_prev_offset;
            end
            exp_wave = wave_of_phase(p);
            mag = i_freq_hz[31] ? -i_freq_hz : i_freq_hz;
            st = turn_advance(mag, osc_inv_sr);
            osc_phase = i_freq_hz[31] ? p - st : p + st;
            osc_prev_offset = i_phase_offset;
            wave_due.push_back(pin_valid ? pin_wave : exp_wave);
        end
    end

    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (no_idle || $urandom_range(0, 2) != 0) begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    task automatic put_beat(input logic [31:0] freq, input logic [31:0] offs,
                            input logic [31:0] sync, input logic pinned,
                            input logic [31:0] wave);
        t_row r;
        r = '{ROW_BEAT, freq, offs, sync, pinned, wave, 64'd0};
        stim_table.push_back(r);
    endtask

    task automatic put_cfg(input logic [63:0] value);
        t_row r;
        r = '{ROW_CFG, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, value};
        stim_table.push_back(r);
    endtask

    task automatic send_beat(input t_row r);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_freq_hz <= r.freq;
        i_phase_offset <= r.offs;
        i_sync_value <= r.sync;
        pin_valid <= r.pinned;
        pin_wave <= r.wave;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (wave_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_inv_sr(input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_INV_SR, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[INV_SR_W-1:0] !== value[INV_SR_W-1:0]) begin
            $error("inv_sample_rate: expected %0d, got %0d",
                   value[INV_SR_W-1:0], prdata[INV_SR_W-1:0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_row        r;
        logic [63:0] phase_rate[RAND_PHASES];
        logic [31:0] last_offs;
        int          sel;

        put_beat(32'd0, 32'd0, 32'd0, 1'b1, 32'd0);
        put_beat(32'd0, 32'h4000_0000, 32'd0, 1'b1, WAVE_ONE);
        put_beat(32'd0, 32'h4000_0000, 32'd0, 1'b1, WAVE_ONE);
        put_beat(32'd0, 32'hFFFF_FFFF, SYNC_ONE, 1'b1, 32'd0);
        put_beat(FREQ_MAX, 32'h1234_5678, 32'h1000_0000, 1'b1, WAVE_ONE);
        put_beat(FREQ_MIN, 32'h0, 32'h3000_0000, 1'b1, -WAVE_ONE);
        put_beat(32'd0, 32'h0, 32'h2000_0000, 1'b1, 32'd0);
        put_beat(32'd1, 32'h0, 32'h4000_0001, 1'b0, 32'd0);
        put_beat(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'd0);
        put_beat(32'h01B8_0000, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        put_beat(32'h01B8_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0);
        put_beat(32'h01B8_0000, 32'h0, 32'd1, 1'b0, 32'd0);
        put_beat(32'hFE48_0000, 32'h0, 32'd0, 1'b0, 32'd0);
        put_cfg(INV_SR_MAX);
        put_beat(FREQ_MAX, 32'hA5A5_A5A5, SYNC_ONE, 1'b1, 32'd0);
        put_beat(FREQ_MAX, 32'hA5A5_A5A5, 32'd0, 1'b1, 32'd0);
        put_beat(FREQ_MIN, 32'hA5A5_A5A5, 32'd0, 1'b1, 32'd0);
        put_beat(32'h1234_5678, 32'hA5A5_A5A5, 32'd0, 1'b1, 32'd0);
        put_beat(32'h0000_0001, 32'h5A5A_5A5A, 32'd0, 1'b0, 32'd0);
        put_cfg(64'd0);
        put_beat(FREQ_MAX, 32'h0, 32'h1000_0000, 1'b1, WAVE_ONE);
        put_beat(FREQ_MAX, 32'h0, 32'd0, 1'b1, WAVE_ONE);
        put_beat(FREQ_MIN, 32'hC000_0000, 32'd0, 1'b1, 32'd0);
        put_cfg(64'd1);
        put_beat(FREQ_MAX, 32'h0, 32'h1000_0000, 1'b1, WAVE_ONE);
        put_beat(FREQ_MIN, 32'h0, 32'd0, 1'b0, 32'd0);
        put_cfg(INV_SR_FULL_TURN);
        put_beat(FREQ_MIN, 32'h0, 32'h1000_0000, 1'b1, WAVE_ONE);
        put_beat(FREQ_MIN, 32'h0, 32'd0, 1'b1, WAVE_ONE);
        put_cfg(64'(INV_SR_RESET));

        phase_rate[0] = 64'(INV_SR_RESET);
        phase_rate[1] = 64'd6382504663;
        phase_rate[2] = ({$urandom, $urandom} % INV_SR_MAX) + 64'd1;
        phase_rate[3] = INV_SR_MAX;
        phase_rate[4] = 64'd1466015503;
        phase_rate[5] = ({$urandom, $urandom} % INV_SR_MAX) + 64'd1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            if (stim_table[k].kind == ROW_CFG) begin
                drain();
                write_inv_sr(stim_table[k].cfg);
            end else begin
                send_beat(stim_table[k]);
            end
        end

        last_offs = osc_prev_offset;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            write_inv_sr(phase_rate[ph]);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (ph == RAND_PHASES - 1 && n >= BEATS_PER_PHASE - QUIET_BEATS)
                    no_idle = 1'b1;
                r = '0;
                r.kind = ROW_BEAT;
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    r.freq = $urandom_range(0, 2 * AUDIO_SPAN) - AUDIO_SPAN;
                end else if (sel < 85) begin
                    r.freq = $urandom;
                end else begin
                    case ($urandom_range(0, 4))
                        0: r.freq = FREQ_MAX;
                        1: r.freq = FREQ_MIN;
                        2: r.freq = 32'd0;
                        3: r.freq = 32'd1;
                        default: r.freq = 32'hFFFF_FFFF;
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    r.offs = last_offs;
                else if (sel < 70)
                    r.offs = last_offs + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                else
                    r.offs = $urandom;
                last_offs = r.offs;
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    r.sync = 32'd0;
                end else if (sel < 80) begin
                    r.sync = $urandom_range(1, SYNC_ONE);
                end else if (sel < 85) begin
                    case ($urandom_range(0, 2))
                        0: r.sync = SYNC_ONE;
                        1: r.sync = 32'd1;
                        default: r.sync = SYNC_ONE + 32'd1;
                    endcase
                end else begin
                    r.sync = $urandom;
                end
                send_beat(r);
            end
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (wave_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d wave samples from %0d beats, %0d of them sync loads.",
                 samples_out, beats_in, sync_loads);
        $display("Sample-rate register written %0d times, covering zero, one and full scale.",
                 rate_writes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### parabolic_oscillator.f
rtl/po_pkg.sv
rtl/po_queue.sv
rtl/po_front.sv
rtl/po_back.sv
rtl/parabolic_oscillator.sv
bench/tb.sv
